FILE: src/mrlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrlm_pkg - shared types and constants of the modem result line matcher
// Holds the reply word table, character codes and the channel item types.
// ----------------------------------------------------------------------------
package mrlm_pkg;

  // Reply word table geometry
  localparam int WORD_COUNT    = 8;
  localparam int CODE_W        = 3;
  localparam int POS_W         = 4;
  localparam int WORD_MAX_LEN  = 14;
  localparam int TEXT_W        = WORD_MAX_LEN * 8;

  localparam logic [POS_W-1:0] POS_MAX = 4'd15;

  // Character codes, parity bit already stripped
  localparam logic [6:0] CHAR_CR  = 7'h0d;
  localparam logic [6:0] CHAR_LF  = 7'h0a;
  localparam logic [6:0] CHAR_SP  = 7'h20;
  localparam logic [6:0] CHAR_TAB = 7'h09;

  // Reply codes
  localparam logic [CODE_W-1:0] REPLY_INITIATING = 3'd0;

  // Reply words, right aligned: last character in the low byte
  localparam logic [TEXT_W-1:0] REPLY_TEXT [WORD_COUNT] = '{
    "INITIATING",
    "NO DIAL TONE",
    "BUSY",
    "NO RINGING",
    "NO ANSWER TONE",
    "NO ANSWER",
    "VOICE DETECTED",
    "CALL FAILED"
  };

  localparam logic [POS_W-1:0] REPLY_LEN [WORD_COUNT] = '{
    4'd10, 4'd12, 4'd4, 4'd10, 4'd14, 4'd9, 4'd14, 4'd11
  };

  // Channel items
  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              connected;
    logic [CODE_W-1:0] reply_code;
  } out_item_t;

  // Character of word k at position p; meaningful only while p < length
  function automatic logic [7:0] reply_char(input logic [CODE_W-1:0] k,
                                            input logic [POS_W-1:0] p);
    logic [POS_W-1:0]  idx;
    logic [TEXT_W-1:0] word;
    idx  = REPLY_LEN[k] - p - 4'd1;
    word = REPLY_TEXT[k] >> {idx, 3'b000};
    return word[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/mrlm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrlm_in_if / mrlm_out_if - valid/ready channels of the line matcher
// One interface per channel; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface mrlm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrlm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      connected;
  logic [mrlm_pkg::CODE_W-1:0] reply_code;

  modport source (output valid, output connected, output reply_code, input ready);
  modport sink   (input valid, input connected, input reply_code, output ready);
endinterface
`default_nettype wire

FILE: src/modem_result_line_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modem_result_line_matcher - modem reply line matcher
// Strips parity, skips leading blanks, tracks the reply word prefixes of the
// current line and reports the first matching word when a line closes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | handshake
//  in_ch    | in  | rx_byte[7:0]                   | valid / ready
//  out_ch   | out | connected, reply_code[2:0]     | valid / ready
//
//  One item per cycle sustained; an item is taken into the input register,
//  then matched and retired from it, and a result is loaded into the result
//  register as its closing CR or LF retires.
//  Reset (rst_n low, synchronous) empties both registers and clears the line.
//  A held result stalls only a closing byte that would give a result; other
//  items keep flowing past it.
// ----------------------------------------------------------------------------
module modem_result_line_matcher (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrlm_in_if.sink     in_ch,
  mrlm_out_if.source  out_ch
);

  localparam int N = mrlm_pkg::WORD_COUNT;

  // Input register
  logic                       s1_valid_r;
  logic [7:0]                 s1_byte_r;

  // Line state
  logic [N-1:0]               match_r, match_nxt;
  logic [mrlm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       started_r, started_nxt;

  // Result register
  logic                       out_valid_r;
  mrlm_pkg::out_item_t        out_r, out_nxt;

  logic [6:0]                 ch;
  logic                       is_eol, is_blank;
  logic [N-1:0]               mismatch, complete;
  logic                       hit;
  logic [mrlm_pkg::CODE_W-1:0] hit_code;
  logic                       give_result, line_clear;
  logic                       out_free, s1_advance, in_fire;

  // Decode the byte held in the input register
  assign ch       = s1_byte_r[6:0];
  assign is_eol   = (ch == mrlm_pkg::CHAR_CR) || (ch == mrlm_pkg::CHAR_LF);
  assign is_blank = (ch == mrlm_pkg::CHAR_SP) || (ch == mrlm_pkg::CHAR_TAB);

  // Compare against every reply word in parallel
  always_comb begin
    for (int k = 0; k < N; k++) begin
      mismatch[k] = (pos_r < mrlm_pkg::REPLY_LEN[k]) &&
                    (mrlm_pkg::reply_char(mrlm_pkg::CODE_W'(k), pos_r) != {1'b0, ch});
      complete[k] = match_r[k] && (pos_r >= mrlm_pkg::REPLY_LEN[k]);
    end
  end

  // Pick the first complete word in table order
  always_comb begin
    hit_code = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (complete[k]) begin
        hit_code = mrlm_pkg::CODE_W'(k);
      end
    end
  end
  assign hit = |complete;

  assign line_clear  = is_eol && started_r;
  assign give_result = line_clear && hit;

  // Handshake: hold a result-giving item while the result register is full and not being taken
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && (!give_result || out_free);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Next line state
  always_comb begin
    match_nxt   = match_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    priority if (line_clear) begin
      match_nxt   = '1;
      pos_nxt     = '0;
      started_nxt = 1'b0;
    end else if (is_eol || (is_blank && !started_r)) begin
      // blank line or leading blank: leave the line untouched
    end else begin
      match_nxt   = match_r & ~mismatch;
      pos_nxt     = (pos_r < mrlm_pkg::POS_MAX) ? pos_r + 4'd1 : pos_r;
      started_nxt = 1'b1;
    end
  end

  always_comb begin
    out_nxt.connected  = (hit_code == mrlm_pkg::REPLY_INITIATING);
    out_nxt.reply_code = hit_code;
  end

  // Advance the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Update the line state when an item retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r   <= '1;
      pos_r     <= '0;
      started_r <= 1'b0;
    end else if (s1_advance) begin
      match_r   <= match_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
    end
  end

  // Load or drop the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && give_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && give_result) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.connected  = out_r.connected;
  assign out_ch.reply_code = out_r.reply_code;

  // Checks
  a_idle_line_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (pos_r == '0) && (match_r == '1))
    else $error("line not started but line state dirty");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == mrlm_pkg::POS_MAX) && !(s1_advance && line_clear)
      |=> (pos_r == mrlm_pkg::POS_MAX))
    else $error("position counter wrapped");

  a_result_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && give_result) |=> out_valid_r && !started_r)
    else $error("result given without closing the line");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(s1_advance && give_result))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: dv/modem_result_line_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_result_line_matcher_tb - self-checking bench for the reply line matcher
// Streams received bytes (reply words, damaged words, long lines, blank lines
// and noise) through the input channel under four idling phases, predicts
// each closed line's reply and checks every result item in order.
// ----------------------------------------------------------------------------
module modem_result_line_matcher_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 280;
  localparam int DRAIN_CYCLES = 8;

  // Reply words in table order
  typedef enum logic [mrlm_pkg::CODE_W-1:0] {
    W_INITIATING, W_NO_DIAL_TONE, W_BUSY, W_NO_RINGING,
    W_NO_ANSWER_TONE, W_NO_ANSWER, W_VOICE_DETECTED, W_CALL_FAILED
  } reply_word_t;

  string reply_word [mrlm_pkg::WORD_COUNT] = '{
    "INITIATING", "NO DIAL TONE", "BUSY", "NO RINGING",
    "NO ANSWER TONE", "NO ANSWER", "VOICE DETECTED", "CALL FAILED"
  };

  logic clk;
  logic rst_n;

  mrlm_in_if  in_ch ();
  mrlm_out_if out_ch ();

  modem_result_line_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Line tracking copy of the matcher
  logic [mrlm_pkg::WORD_COUNT-1:0] prefix_alive;
  logic [mrlm_pkg::POS_W-1:0]      line_pos;
  bit                              line_open;

  logic [7:0]          byte_queue [$];
  mrlm_pkg::out_item_t reply_due [$];

  int send_idle_pct;
  int sink_stall_pct;
  int bytes_queued;
  int bytes_taken;
  int lines_closed;
  int replies_checked;
  int connects_seen;
  int error_count;
  int cycle_count;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance the line state by one byte; return 1 when a reply is due
  function automatic bit predict_reply(input logic [7:0] rx,
                                       output mrlm_pkg::out_item_t reply);
    logic [6:0] ch;
    logic [7:0] want;
    bit         hit;
    string      w;
    ch    = rx[6:0];
    hit   = 1'b0;
    reply = '0;
    if (ch == mrlm_pkg::CHAR_CR || ch == mrlm_pkg::CHAR_LF) begin
      if (line_open) begin
        lines_closed++;
        for (int k = 0; k < mrlm_pkg::WORD_COUNT; k++) begin
          if (!hit && prefix_alive[k] && line_pos >= reply_word[k].len()) begin
            hit              = 1'b1;
            reply.reply_code = mrlm_pkg::CODE_W'(k);
            reply.connected  = (reply.reply_code == mrlm_pkg::REPLY_INITIATING);
          end
        end
        prefix_alive = '1;
        line_pos     = '0;
        line_open    = 1'b0;
      end
    end else if (line_open || (ch != mrlm_pkg::CHAR_SP && ch != mrlm_pkg::CHAR_TAB)) begin
      for (int k = 0; k < mrlm_pkg::WORD_COUNT; k++) begin
        w = reply_word[k];
        if (line_pos < w.len()) begin
          want = w[line_pos];
          if (want != {1'b0, ch}) prefix_alive[k] = 1'b0;
        end
      end
      if (line_pos != mrlm_pkg::POS_MAX) line_pos = line_pos + 1'b1;
      line_open = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [7:0] with_parity(input logic [6:0] c);
    return {1'($urandom_range(0, 1)), c};
  endfunction

  // Random line character, never a line terminator
  function automatic logic [6:0] line_char();
    logic [6:0] c;
    c = 7'($urandom_range(0, 127));
    if (c == mrlm_pkg::CHAR_CR || c == mrlm_pkg::CHAR_LF) c = 7'h58;
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s, input bit set_parity);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      push_byte({set_parity, c[6:0]});
    end
  endtask

  // Leading blanks, a word (whole, cut short, damaged or overlong) or noise,
  // then CR, LF or CR LF
  task automatic push_random_line();
    int         mode;
    int         n;
    int         cut;
    int         bad_at;
    logic [7:0] c;
    string      w;
    mode = $urandom_range(0, 99);
    n    = $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      push_byte(with_parity($urandom_range(0, 1) ? mrlm_pkg::CHAR_SP : mrlm_pkg::CHAR_TAB));
    if (mode < 85) begin
      w      = reply_word[$urandom_range(0, mrlm_pkg::WORD_COUNT - 1)];
      cut    = w.len();
      bad_at = -1;
      if (mode >= 55 && mode < 65) cut = $urandom_range(1, w.len() - 1);
      if (mode >= 65 && mode < 75) bad_at = $urandom_range(0, w.len() - 1);
      for (int i = 0; i < cut; i++) begin
        c = w[i];
        push_byte(with_parity(i == bad_at ? line_char() : c[6:0]));
      end
      n = 0;
      if (mode < 55) n = $urandom_range(0, 4);
      if (mode >= 75) n = $urandom_range(6, 12);
      for (int i = 0; i < n; i++) push_byte(with_parity(line_char()));
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 2))
      0: push_byte(with_parity(mrlm_pkg::CHAR_CR));
      1: push_byte(with_parity(mrlm_pkg::CHAR_LF));
      default: begin
        push_byte(with_parity(mrlm_pkg::CHAR_CR));
        push_byte(with_parity(mrlm_pkg::CHAR_LF));
      end
    endcase
  endtask

  task automatic wait_taken();
    while (bytes_taken != bytes_queued) @(posedge clk);
  endtask

  // Driver: offer the next pending byte, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= byte_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Monitor: check results against the oldest expected reply, then predict
  always @(posedge clk) begin
    mrlm_pkg::out_item_t got;
    mrlm_pkg::out_item_t due;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d replies outstanding",
               $time, cycle_count, reply_due.size());
      $display("modem_result_line_matcher verification failed");
      $finish;
    end
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.connected  = out_ch.connected;
        got.reply_code = out_ch.reply_code;
        if (reply_due.size() == 0) begin
          $display("%0t unexpected reply: expected none, got connected=%0b code=%0d",
                   $time, got.connected, got.reply_code);
          error_count++;
        end else begin
          due = reply_due.pop_front();
          replies_checked++;
          if (got.connected == 1'b1) connects_seen++;
          if (got.connected !== due.connected) begin
            $display("%0t connected mismatch: expected %0b, got %0b",
                     $time, due.connected, got.connected);
            error_count++;
          end
          if (got.reply_code !== due.reply_code) begin
            $display("%0t reply_code mismatch: expected %0d, got %0d",
                     $time, due.reply_code, got.reply_code);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        if (predict_reply(in_ch.rx_byte, due)) reply_due.push_back(due);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    prefix_alive   = '1;
    line_pos       = '0;
    line_open      = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: every word, blanks, parity, NUL, long lines, non-matches
    push_text({reply_word[W_INITIATING], "\r"}, 1'b0);
    push_text({reply_word[W_NO_DIAL_TONE], "\n"}, 1'b0);
    push_text({"  \t", reply_word[W_BUSY], "\r"}, 1'b0);
    push_text({reply_word[W_NO_RINGING], "\r\n"}, 1'b0);
    push_text({reply_word[W_NO_ANSWER_TONE], "\r"}, 1'b0);
    push_text({reply_word[W_NO_ANSWER], "\r"}, 1'b0);
    push_text({reply_word[W_VOICE_DETECTED], " AND MORE\r"}, 1'b0);
    push_text({reply_word[W_CALL_FAILED], "\n"}, 1'b0);
    push_text({reply_word[W_INITIATING], "\r"}, 1'b1);
    push_text("\r\n\t \r", 1'b0);
    push_text(" \t \n", 1'b1);
    push_text("NO ANSWER TON\r", 1'b0);
    push_text("NO DIAL TON\r", 1'b0);
    push_text("NO  DIAL TONE\r", 1'b0);
    push_text("BUSY LINE HELD UP\r", 1'b0);
    push_text("OK\r", 1'b0);
    push_text("BUS", 1'b0);
    push_byte(8'h00);
    push_text("\r", 1'b0);
    push_byte(8'h00);
    push_text("BUSY\r", 1'b0);
    push_text("BUSY", 1'b0);
    push_byte(8'h00);
    push_byte(8'h8d);
    push_byte(8'hff);
    push_byte(8'h7f);
    push_byte(8'h80);
    push_byte(8'h8a);

    // Random lines under four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      int start;
      case (phase)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 63; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin send_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) push_random_line();
      wait_taken();
    end

    while (reply_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d closed lines under four idling phases;",
             bytes_taken, lines_closed);
    $display("checked %0d replies, %0d of them connects.", replies_checked, connects_seen);
    if (error_count == 0 && reply_due.size() == 0) begin
      $display("modem_result_line_matcher verification clean");
    end else begin
      $display("modem_result_line_matcher verification failed");
    end
    $finish;
  end

endmodule
